// ===== src/multibit_trie_lpm_top_assert.svh =====
// Assertion helpers for the trie lookup block.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef MULTIBIT_TRIE_LPM_TOP_ASSERT_SVH
`define MULTIBIT_TRIE_LPM_TOP_ASSERT_SVH

// Same-cycle implication.
`define MTLPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MTLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mtlpm_pkg.sv =====
`default_nettype none
package mtlpm_pkg;

    localparam int KEY_W    = 32;
    localparam int LEN_W    = 6;
    localparam int HOPP_W   = 16;
    localparam int POS_W    = 7;
    localparam int NEED_W   = 10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_POOL = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CNT_EVAL,
        OP_EXP_START,
        OP_APL_START,
        OP_APL_EVAL,
        OP_NODE_CUR,
        OP_INFO_EVAL,
        OP_LK_INFO,
        OP_LK_CHILD,
        OP_ST_LEN,
        OP_ST_POOL,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic func;
        logic len_bad;
        logic len_zero;
        logic full;
        logic rem;
        logic exp;
        logic present;
        logic exp_last;
        logic child_zero;
        logic fits;
        logic lk_end;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

// ===== src/mtlpm_ctrl.sv =====
`default_nettype none
module mtlpm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire mtlpm_pkg::t_stat i_stat,
    output mtlpm_pkg::t_cmd      o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_CHECK = 16'h0002,
        S_CDEC  = 16'h0004,
        S_CRD   = 16'h0008,
        S_CEV   = 16'h0010,
        S_CHK2  = 16'h0020,
        S_ADEC  = 16'h0040,
        S_ARD   = 16'h0080,
        S_AEV   = 16'h0100,
        S_IRD   = 16'h0200,
        S_IEV   = 16'h0400,
        S_LIRD  = 16'h0800,
        S_LIEV  = 16'h1000,
        S_LCRD  = 16'h2000,
        S_LCEV  = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = !((r_state == S_IDLE) && i_stat.clr_done);

    // Next state and operation
    always_comb begin
        n_state  = r_state;
        o_cmd.op = mtlpm_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.clr_done) begin
                    o_cmd.op = mtlpm_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.func) begin
                    n_state = S_LIRD;
                end else if (i_stat.len_bad) begin
                    o_cmd.op = mtlpm_pkg::OP_ST_LEN;
                    n_state  = S_DONE;
                end else if (i_stat.len_zero) begin
                    n_state = S_IRD;
                end else begin
                    n_state = S_CDEC;
                end
            end
            S_CDEC: begin
                if (i_stat.full) begin
                    n_state = S_CRD;
                end else if (i_stat.rem && !i_stat.exp) begin
                    o_cmd.op = mtlpm_pkg::OP_EXP_START;
                    n_state  = i_stat.present ? S_CRD : S_CHK2;
                end else begin
                    n_state = S_CHK2;
                end
            end
            S_CRD: n_state = S_CEV;
            S_CEV: begin
                o_cmd.op = mtlpm_pkg::OP_CNT_EVAL;
                if (i_stat.exp) n_state = i_stat.exp_last ? S_CHK2 : S_CRD;
                else            n_state = S_CDEC;
            end
            S_CHK2: begin
                if (i_stat.fits) begin
                    o_cmd.op = mtlpm_pkg::OP_APL_START;
                    n_state  = S_ADEC;
                end else begin
                    o_cmd.op = mtlpm_pkg::OP_ST_POOL;
                    n_state  = S_DONE;
                end
            end
            S_ADEC: begin
                if (i_stat.full) begin
                    n_state = S_ARD;
                end else if (i_stat.rem && !i_stat.exp) begin
                    o_cmd.op = mtlpm_pkg::OP_EXP_START;
                    n_state  = S_ARD;
                end else begin
                    o_cmd.op = mtlpm_pkg::OP_NODE_CUR;
                    n_state  = S_IRD;
                end
            end
            S_ARD: n_state = S_AEV;
            S_AEV: begin
                o_cmd.op = mtlpm_pkg::OP_APL_EVAL;
                n_state  = i_stat.exp ? S_IRD : S_ADEC;
            end
            S_IRD: n_state = S_IEV;
            S_IEV: begin
                o_cmd.op = mtlpm_pkg::OP_INFO_EVAL;
                n_state  = (i_stat.exp && !i_stat.exp_last) ? S_ARD : S_DONE;
            end
            S_LIRD: n_state = S_LIEV;
            S_LIEV: begin
                o_cmd.op = mtlpm_pkg::OP_LK_INFO;
                n_state  = i_stat.lk_end ? S_DONE : S_LCRD;
            end
            S_LCRD: n_state = S_LCEV;
            S_LCEV: begin
                o_cmd.op = mtlpm_pkg::OP_LK_CHILD;
                n_state  = i_stat.child_zero ? S_DONE : S_LIRD;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = mtlpm_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule
`default_nettype wire

// ===== src/mtlpm_dp.sv =====
`default_nettype none
module mtlpm_dp #(
    parameter int STRIDE    = 4,
    parameter int NODE_POOL = 1024,
    parameter int HOP_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mtlpm_pkg::t_cmd               i_cmd,
    output mtlpm_pkg::t_stat                   o_stat,
    input  wire logic                          i_func,
    input  wire logic [mtlpm_pkg::KEY_W-1:0]   i_key_bits,
    input  wire logic [mtlpm_pkg::LEN_W-1:0]   i_prefix_len,
    input  wire logic [mtlpm_pkg::HOPP_W-1:0]  i_hop_in,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_found,
    output logic [mtlpm_pkg::HOPP_W-1:0]       o_hop_out,
    output logic [1:0]                         o_status
);

    localparam int NW  = $clog2(NODE_POOL);
    localparam int UW  = NW + 1;
    localparam int CAW = NW + STRIDE;
    localparam int CD  = NODE_POOL << STRIDE;
    localparam int IW  = 1 + mtlpm_pkg::LEN_W + HOP_WIDTH;
    localparam int SW  = ((UW > mtlpm_pkg::NEED_W) ? UW : mtlpm_pkg::NEED_W) + 1;
    localparam int PW  = mtlpm_pkg::POS_W;

    // Child index table and per-node prefix info
    logic [NW-1:0] child_mem [CD];
    logic [IW-1:0] info_mem  [NODE_POOL];
    logic [NW-1:0] r_child_q;
    logic [IW-1:0] r_info_q;

    logic                         r_func;
    logic [mtlpm_pkg::KEY_W-1:0]  r_key, r_sh;
    logic [mtlpm_pkg::LEN_W-1:0]  r_len;
    logic [HOP_WIDTH-1:0]         r_hop, r_best;
    logic [NW-1:0]                r_cur, r_node;
    logic [PW-1:0]                r_pos;
    logic [STRIDE-1:0]            r_i;
    logic                         r_exp, r_present, r_hit;
    logic [mtlpm_pkg::NEED_W-1:0] r_need;
    logic [UW-1:0]                r_used;
    logic [CAW:0]                 r_clr;
    logic                         r_out_valid, r_found;
    logic [HOP_WIDTH-1:0]         r_out_hop;
    logic [1:0]                   r_out_st;
    logic [1:0]                   r_status;

    logic [STRIDE-1:0] grp, mask, slot;
    logic [PW-1:0]     rem_len, len7, pos_nx;
    logic [CAW-1:0]    caddr;
    logic              child_zero, clr_done, q_has, alloc, offer;
    logic [mtlpm_pkg::LEN_W-1:0] q_len;
    logic [SW-1:0]     total;

    // Slot selection: group of the key, or an expansion sibling
    assign grp        = r_sh[mtlpm_pkg::KEY_W-1 -: STRIDE];
    assign len7       = {1'b0, r_len};
    assign rem_len    = len7 - r_pos;
    assign mask       = STRIDE'({STRIDE{1'b1}} >> rem_len);
    assign slot       = r_exp ? ((grp & ~mask) | (r_i & mask)) : grp;
    assign caddr      = {r_cur, slot};
    assign pos_nx     = r_pos + PW'(STRIDE);
    assign child_zero = (r_child_q == '0);
    assign clr_done   = r_clr[CAW];
    assign q_has      = r_info_q[IW-1];
    assign q_len      = r_info_q[IW-2 -: mtlpm_pkg::LEN_W];
    assign total      = SW'(r_used) + SW'(r_need);
    assign alloc      = (i_cmd.op == mtlpm_pkg::OP_APL_EVAL) && child_zero;
    assign offer      = (i_cmd.op == mtlpm_pkg::OP_INFO_EVAL) && (!q_has || (r_len > q_len));

    always_comb begin
        o_stat.clr_done   = clr_done;
        o_stat.func       = r_func;
        o_stat.len_bad    = r_len > mtlpm_pkg::LEN_W'(mtlpm_pkg::KEY_W);
        o_stat.len_zero   = (r_len == '0);
        o_stat.full       = pos_nx <= len7;
        o_stat.rem        = r_pos < len7;
        o_stat.exp        = r_exp;
        o_stat.present    = r_present;
        o_stat.exp_last   = (r_i == mask);
        o_stat.child_zero = child_zero;
        o_stat.fits       = total <= SW'(NODE_POOL);
        o_stat.lk_end     = r_pos >= PW'(mtlpm_pkg::KEY_W);
        o_stat.out_busy   = r_out_valid && i_out_stall;
    end

    // Memory ports: clearing sweep after reset, then walk writes
    always_ff @(posedge i_clk) begin
        r_child_q <= child_mem[caddr];
        r_info_q  <= info_mem[r_node];
        if (!clr_done) begin
            child_mem[r_clr[CAW-1:0]] <= '0;
            info_mem[r_clr[NW-1:0]]   <= '0;
        end else begin
            if (alloc)  child_mem[caddr] <= r_used[NW-1:0];
            if (offer)  info_mem[r_node] <= {1'b1, r_len, r_hop};
        end
    end

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_used      <= UW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (!clr_done) r_clr <= r_clr + 1'b1;
            if (alloc) r_used <= r_used + 1'b1;
            if (i_cmd.op == mtlpm_pkg::OP_OUT) r_out_valid <= 1'b1;
            else if (!i_out_stall)             r_out_valid <= 1'b0;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mtlpm_pkg::OP_LOAD: begin
                r_func    <= i_func;
                r_key     <= i_key_bits;
                r_sh      <= i_key_bits;
                r_len     <= i_prefix_len;
                r_hop     <= HOP_WIDTH'(i_hop_in);
                r_cur     <= '0;
                r_node    <= '0;
                r_pos     <= '0;
                r_i       <= '0;
                r_exp     <= 1'b0;
                r_present <= 1'b1;
                r_need    <= '0;
                r_hit     <= 1'b0;
                r_best    <= '0;
                r_out_st  <= mtlpm_pkg::ST_OK;
            end
            mtlpm_pkg::OP_CNT_EVAL: begin
                if (r_exp) begin
                    if (child_zero) r_need <= r_need + 1'b1;
                    if (r_i != mask) r_i <= r_i + 1'b1;
                end else begin
                    if (r_present && !child_zero) begin
                        r_cur <= r_child_q;
                    end else begin
                        r_present <= 1'b0;
                        r_need    <= r_need + 1'b1;
                    end
                    r_pos <= pos_nx;
                    r_sh  <= r_sh << STRIDE;
                end
            end
            mtlpm_pkg::OP_EXP_START: begin
                r_exp <= 1'b1;
                r_i   <= '0;
                if (!r_present) r_need <= r_need + mtlpm_pkg::NEED_W'(mask) + 1'b1;
            end
            mtlpm_pkg::OP_APL_START: begin
                r_cur <= '0;
                r_pos <= '0;
                r_sh  <= r_key;
                r_exp <= 1'b0;
                r_i   <= '0;
            end
            mtlpm_pkg::OP_APL_EVAL: begin
                if (r_exp) begin
                    r_node <= child_zero ? r_used[NW-1:0] : r_child_q;
                end else begin
                    r_cur <= child_zero ? r_used[NW-1:0] : r_child_q;
                    r_pos <= pos_nx;
                    r_sh  <= r_sh << STRIDE;
                end
            end
            mtlpm_pkg::OP_NODE_CUR: r_node <= r_cur;
            mtlpm_pkg::OP_INFO_EVAL: begin
                if (r_exp && (r_i != mask)) r_i <= r_i + 1'b1;
            end
            mtlpm_pkg::OP_LK_INFO: begin
                if (q_has) begin
                    r_hit  <= 1'b1;
                    r_best <= r_info_q[HOP_WIDTH-1:0];
                end
            end
            mtlpm_pkg::OP_LK_CHILD: begin
                if (!child_zero) begin
                    r_cur  <= r_child_q;
                    r_node <= r_child_q;
                    r_pos  <= pos_nx;
                    r_sh   <= r_sh << STRIDE;
                end
            end
            mtlpm_pkg::OP_ST_LEN:  r_out_st <= mtlpm_pkg::ST_LEN;
            mtlpm_pkg::OP_ST_POOL: r_out_st <= mtlpm_pkg::ST_POOL;
            mtlpm_pkg::OP_OUT: begin
                r_found   <= r_hit;
                r_out_hop <= r_best;
                r_status  <= r_out_st;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_hop_out   = mtlpm_pkg::HOPP_W'(r_out_hop);
    assign o_status    = r_status;

endmodule
`default_nettype wire

// ===== src/multibit_trie_lpm_top.sv =====
`default_nettype none
// Longest-prefix match over a fixed-stride multibit trie held in two single-port
// memories with registered reads. After reset a clearing sweep over the
// NODE_POOL << STRIDE child entries (16384 at the defaults) runs while the input
// is stalled. Items are processed one at a time. A lookup descends one trie level
// per child read until a child is missing or the key ends. An insert first counts
// the new nodes it needs, then applies its walk, expanding a short remainder over
// its sibling slots; a rejected length goes straight to the result. Each memory
// read is registered before its data can steer the walk.
// The result register lets the next item enter while a result waits; a finished
// item holds until that register is free.
module multibit_trie_lpm_top #(
    parameter int STRIDE    = 4,
    parameter int NODE_POOL = 1024,
    parameter int HOP_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_key_bits,
    input  wire logic [5:0]  i_prefix_len,
    input  wire logic [15:0] i_hop_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_found,
    output logic [15:0]      o_hop_out,
    output logic [1:0]       o_status
);

`include "multibit_trie_lpm_top_assert.svh"

    mtlpm_pkg::t_cmd  cmd;
    mtlpm_pkg::t_stat stat;

    mtlpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mtlpm_dp #(
        .STRIDE    (STRIDE),
        .NODE_POOL (NODE_POOL),
        .HOP_WIDTH (HOP_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_key_bits   (i_key_bits),
        .i_prefix_len (i_prefix_len),
        .i_hop_in     (i_hop_in),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_found      (o_found),
        .o_hop_out    (o_hop_out),
        .o_status     (o_status)
    );

    // Result consistency and one-item-at-a-time intake
    `MTLPM_ASSERT_NOW(a_status_code, o_out_valid, o_status <= mtlpm_pkg::ST_POOL, "bad status")
    `MTLPM_ASSERT_NOW(a_no_hit_no_hop, o_out_valid && !o_found, o_hop_out == '0, "hop w/o hit")
    `MTLPM_ASSERT_NOW(a_insert_no_hit, o_out_valid && (o_status != mtlpm_pkg::ST_OK), !o_found, "hit")
    `MTLPM_ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, o_in_stall, "took two items")

endmodule
`default_nettype wire

// ===== tb/sv/tb_multibit_trie_lpm_top.sv =====
module tb_multibit_trie_lpm_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STRIDE     = 4;
    localparam int NODE_POOL  = 1024;
    localparam int HOP_WIDTH  = 16;
    localparam int FANOUT     = 1 << STRIDE;
    localparam int N_RANDOM   = 1300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK   = mtlpm_pkg::ST_OK;
    localparam logic [1:0] ST_LEN  = mtlpm_pkg::ST_LEN;
    localparam logic [1:0] ST_POOL = mtlpm_pkg::ST_POOL;

    typedef struct packed {
        logic        found;
        logic [15:0] hop;
        logic [1:0]  status;
    } t_lpm_result;

    // one directed transfer; typed = 1 means the expected result is given here
    typedef struct packed {
        logic        func;
        logic [31:0] key;
        logic [5:0]  len;
        logic [15:0] hop;
        logic        typed;
        logic        efound;
        logic [15:0] ehop;
        logic [1:0]  est;
    } t_route_row;

    localparam int N_DIR = 24;
    localparam t_route_row ROUTE_ROWS [0:N_DIR-1] = '{
        '{FN_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h0102_0304, 6'd33, 16'h0011, 1'b1, 1'b0, 16'h0000, ST_LEN},
        '{FN_INSERT, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, 1'b0, 16'h0000, ST_LEN},
        '{FN_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h0000_0000, 6'd0,  16'hFFFF, 1'b1, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'hA5A5_A5A5, 6'd0,  16'h0001, 1'b1, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'h1234_5678, 6'd0,  16'h0000, 1'b1, 1'b1, 16'hFFFF, ST_OK},
        '{FN_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h1234, 1'b1, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'hFFFF_FFFE, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h0A00_0000, 6'd6,  16'h0005, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h0A00_0000, 6'd6,  16'h0007, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h0A00_0000, 6'd8,  16'h0006, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'h0A01_0203, 6'd17, 16'hBEEF, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'h0B00_0000, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'h0800_0000, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h8000_0000, 6'd1,  16'h8000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'hC000_0000, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h0000_0000, 6'd32, 16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h7FFF_FFFE, 6'd31, 16'h00AA, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'h7FFF_FFFF, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_INSERT, 32'h0A00_0000, 6'd4,  16'h0009, 1'b0, 1'b0, 16'h0000, ST_OK},
        '{FN_LOOKUP, 32'h0A00_0000, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, ST_OK}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = 1'b0;
    logic [31:0] i_key_bits = '0;
    logic [5:0]  i_prefix_len = '0;
    logic [15:0] i_hop_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_found;
    logic [15:0] o_hop_out;
    logic [1:0]  o_status;

    multibit_trie_lpm_top #(
        .STRIDE(STRIDE), .NODE_POOL(NODE_POOL), .HOP_WIDTH(HOP_WIDTH)
    ) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_func(i_func), .i_key_bits(i_key_bits),
        .i_prefix_len(i_prefix_len), .i_hop_in(i_hop_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_found(o_found), .o_hop_out(o_hop_out), .o_status(o_status)
    );

    always #4 i_clk = ~i_clk;

    // shadow trie
    logic [10:0] trie_child [NODE_POOL*FANOUT];
    bit          trie_has   [NODE_POOL];
    logic [5:0]  trie_len   [NODE_POOL];
    logic [15:0] trie_hop   [NODE_POOL];
    int          trie_used;

    t_lpm_result route_q[$];
    int  n_errors = 0;
    int  n_results = 0;
    int  n_lookups = 0;
    int  n_hits = 0;
    int  n_len_err = 0;
    int  n_pool_err = 0;
    int  cycle_cnt = 0;
    bit  hold_req = 1'b0;
    bit  quiet = 1'b0;

    function automatic int group_of(logic [31:0] key, int pos);
        return int'((key >> (32 - pos - STRIDE)) & (FANOUT - 1));
    endfunction

    function automatic int alloc_node();
        int n;
        n = trie_used;
        trie_used++;
        trie_has[n] = 1'b0;
        trie_len[n] = '0;
        trie_hop[n] = '0;
        for (int i = 0; i < FANOUT; i++) trie_child[n*FANOUT + i] = '0;
        return n;
    endfunction

    function automatic void offer_route(int n, int len, logic [15:0] hop);
        if (!trie_has[n] || len > int'(trie_len[n])) begin
            trie_has[n] = 1'b1;
            trie_len[n] = len[5:0];
            trie_hop[n] = hop;
        end
    endfunction

    function automatic logic [1:0] add_route(logic [31:0] key, int len, logic [15:0] hop);
        int cur, pos, need, spread, base, cnt, slot;
        bit present;
        if (len > 32) return ST_LEN;
        if (len == 0) begin
            if (!trie_has[0]) offer_route(0, 0, hop);
            return ST_OK;
        end
        // count new nodes first
        cur = 0; pos = 0; need = 0; present = 1'b1;
        while (pos + STRIDE <= len) begin
            slot = cur*FANOUT + group_of(key, pos);
            if (present && trie_child[slot] != 0) cur = int'(trie_child[slot]);
            else begin
                present = 1'b0;
                need++;
            end
            pos += STRIDE;
        end
        if (pos < len) begin
            spread = STRIDE - (len - pos);
            base = (group_of(key, pos) >> spread) << spread;
            cnt = 1 << spread;
            if (!present) need += cnt;
            else
                for (int i = 0; i < cnt; i++)
                    if (trie_child[cur*FANOUT + (base | i)] == 0) need++;
        end
        if (trie_used + need > NODE_POOL) return ST_POOL;
        // apply
        cur = 0; pos = 0;
        while (pos + STRIDE <= len) begin
            slot = cur*FANOUT + group_of(key, pos);
            if (trie_child[slot] == 0) trie_child[slot] = 11'(alloc_node());
            cur = int'(trie_child[slot]);
            pos += STRIDE;
        end
        if (pos < len) begin
            spread = STRIDE - (len - pos);
            base = (group_of(key, pos) >> spread) << spread;
            cnt = 1 << spread;
            for (int i = 0; i < cnt; i++) begin
                slot = cur*FANOUT + (base | i);
                if (trie_child[slot] == 0) trie_child[slot] = 11'(alloc_node());
                offer_route(int'(trie_child[slot]), len, hop);
            end
        end else begin
            offer_route(cur, len, hop);
        end
        return ST_OK;
    endfunction

    function automatic t_lpm_result route_step(logic func, logic [31:0] key,
                                               logic [5:0] len, logic [15:0] hop);
        t_lpm_result r;
        int cur, pos, nxt;
        r = '0;
        if (func == FN_INSERT) begin
            r.status = add_route(key, int'(len), hop);
        end else begin
            if (trie_has[0]) begin
                r.found = 1'b1;
                r.hop = trie_hop[0];
            end
            cur = 0; pos = 0;
            while (pos < 32) begin
                nxt = int'(trie_child[cur*FANOUT + group_of(key, pos)]);
                if (nxt == 0) break;
                cur = nxt;
                pos += STRIDE;
                if (trie_has[cur]) begin
                    r.found = 1'b1;
                    r.hop = trie_hop[cur];
                end
            end
        end
        return r;
    endfunction

    // drive one transfer and wait until it is taken
    task automatic send_item(logic func, logic [31:0] key, logic [5:0] len,
                             logic [15:0] hop, int gap);
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_key_bits   <= key;
        i_prefix_len <= len;
        i_hop_in     <= hop;
        do @(posedge i_clk); while (o_in_stall);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus
    initial begin
        t_lpm_result exp_r;
        logic [31:0] prefix_base [8];
        logic        func;
        logic [31:0] key;
        logic [5:0]  len;
        logic [15:0] hop;
        int          r;
        int          low_bits;

        for (int i = 0; i < NODE_POOL*FANOUT; i++) trie_child[i] = '0;
        for (int i = 0; i < NODE_POOL; i++) begin
            trie_has[i] = 1'b0;
            trie_len[i] = '0;
            trie_hop[i] = '0;
        end
        trie_used = 1;
        for (int i = 0; i < 8; i++) prefix_base[i] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            exp_r = route_step(ROUTE_ROWS[i].func, ROUTE_ROWS[i].key,
                               ROUTE_ROWS[i].len, ROUTE_ROWS[i].hop);
            if (ROUTE_ROWS[i].typed)
                exp_r = '{ROUTE_ROWS[i].efound, ROUTE_ROWS[i].ehop, ROUTE_ROWS[i].est};
            route_q.push_back(exp_r);
            send_item(ROUTE_ROWS[i].func, ROUTE_ROWS[i].key, ROUTE_ROWS[i].len,
                      ROUTE_ROWS[i].hop, pick_gap());
        end

        // sender pause: let everything drain
        i_in_valid <= 1'b0;
        wait (route_q.size() == 0);
        @(posedge i_clk);

        // random traffic, keys clustered around a few prefixes for deep sharing
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) hold_req = 1'b1;
            quiet = (n % 300) >= 240;
            if (n == 800) begin
                i_in_valid <= 1'b0;
                wait (route_q.size() == 0);
                @(posedge i_clk);
            end
            func = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 10) key = $urandom;
            else begin
                low_bits = $urandom_range(0, 32);
                key = prefix_base[$urandom_range(0, 7)];
                if (low_bits > 0)
                    key = key ^ ($urandom & (32'hFFFF_FFFF >> (32 - low_bits)));
            end
            r = $urandom_range(0, 99);
            if (r < 6) len = 6'($urandom_range(33, 63));
            else if (r < 10) len = 6'd0;
            else if (r < 40) len = 6'(4 * $urandom_range(1, 8));
            else len = 6'($urandom_range(1, 32));
            hop = 16'($urandom);
            exp_r = route_step(func, key, len, hop);
            route_q.push_back(exp_r);
            send_item(func, key, len, hop, pick_gap());
        end
        i_in_valid <= 1'b0;

        wait (route_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d transfers: %0d lookups (%0d hits),", n_results, n_lookups, n_hits);
        $display("%0d bad lengths, %0d pool-full inserts; trie ended with %0d of %0d nodes",
                 n_len_err, n_pool_err, trie_used, NODE_POOL);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stall: random short/long stalls, one long hold on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) stall_left = $urandom_range(0, 2);
                else if (r < 12) stall_left = $urandom_range(15, 50);
                i_out_stall <= (r < 12);
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_lpm_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (route_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result found=%0b hop=%h status=%0d",
                         $time, o_found, o_hop_out, o_status);
            end else begin
                exp_r = route_q.pop_front();
                if (o_found !== exp_r.found) begin
                    n_errors++;
                    $display("%0t: found expected %0b actual %0b", $time, exp_r.found, o_found);
                end
                if (o_hop_out !== exp_r.hop) begin
                    n_errors++;
                    $display("%0t: hop expected %h actual %h", $time, exp_r.hop, o_hop_out);
                end
                if (o_status !== exp_r.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                end
                if (exp_r.status == ST_LEN) n_len_err++;
                if (exp_r.status == ST_POOL) n_pool_err++;
                if (exp_r.found) n_hits++;
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall && i_func == FN_LOOKUP) n_lookups++;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_cnt, route_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
